// ===== hdl/utf8_to_utf16_transcoder_core_assert.svh =====
// Assertion macros for the transcoder core.
// Each macro expects signals named clk and rst_n where it is used.
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define U8U_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");
`define U8U_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");
`else
`define U8U_ASSERT_IMPL(lbl, ante, cons)
`define U8U_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/u8u16_pkg.sv =====
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int POINT_W = 21;
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    localparam logic [POINT_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0]  HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0]  LO_SURR   = 16'hDC00;
    localparam logic [UNIT_W-1:0]  TEN_MASK  = 16'h03FF;

    // All units caused by one input byte, oldest in slot 0.
    typedef struct packed {
        logic [MAX_RES-1:0][UNIT_W-1:0] units;
        logic [CNT_W-1:0]               cnt;
        logic                           last;
    } grp_t;

    function automatic logic [UNIT_W-1:0] raw_unit(input logic [BYTE_W-1:0] b);
        return {{(UNIT_W - BYTE_W){1'b0}}, b};
    endfunction

    // A held continuation byte rebuilt from its six payload bits.
    function automatic logic [UNIT_W-1:0] raw_cont(input logic [5:0] bits);
        return raw_unit({2'b10, bits});
    endfunction

endpackage

// ===== hdl/u8u16_if.sv =====
interface u8u16_byte_if;
    import u8u16_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8u16_unit_if;
    import u8u16_pkg::*;

    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              end_of_run;
    logic              end_of_string;

    modport source (output valid, output code_unit, output end_of_run,
                    output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input end_of_run,
                    input end_of_string, output ready);
endinterface

// ===== hdl/utf8_to_utf16_transcoder_core.sv =====
// Throughput: one byte per cycle while each byte yields at most one unit and the
// output is ready; a byte yielding several units holds the output until all are
// taken, and a one-group skid stage keeps input ready registered. Bytes that only
// extend a sequence yield nothing. Reset (rst_n low, asynchronous) clears the
// pending sequence and both buffers.
`include "utf8_to_utf16_transcoder_core_assert.svh"

module utf8_to_utf16_transcoder_core (
    input logic           clk,
    input logic           rst_n,
    u8u16_byte_if.sink    byte_stream,
    u8u16_unit_if.source  unit_stream
);
    import u8u16_pkg::*;

    logic [BYTE_W-1:0]  lead_reg, lead_next;
    logic [POINT_W-1:0] acc_reg, acc_next;
    logic [1:0]         needed_reg, needed_next;
    logic [1:0]         seen_reg, seen_next;
    grp_t               a_reg, a_next;
    grp_t               b_reg, b_next;

    grp_t               grp_new;
    logic               in_fire, out_fire, a_free;
    logic [BYTE_W-1:0]  b;
    logic               last;
    logic               pend, is_cont, complete;
    logic [POINT_W-1:0] acc_ext, v;
    logic [1:0]         seen_ext;
    logic               flush_en, fresh_en;
    logic [POINT_W-1:0] flush_acc;
    logic [1:0]         flush_seen;
    logic               is_lead;
    logic [1:0]         lead_need;
    logic [POINT_W-1:0] lead_bits;

    assign b        = byte_stream.in_byte;
    assign last     = byte_stream.last_byte;
    assign in_fire  = byte_stream.valid && byte_stream.ready;
    assign out_fire = unit_stream.valid && unit_stream.ready;

    assign byte_stream.ready         = (b_reg.cnt == '0);
    assign unit_stream.valid         = (a_reg.cnt != '0);
    assign unit_stream.code_unit     = a_reg.units[0];
    assign unit_stream.end_of_run    = (a_reg.cnt == CNT_W'(1));
    assign unit_stream.end_of_string = (a_reg.cnt == CNT_W'(1)) && a_reg.last;

    assign pend     = (needed_reg != 2'd0);
    assign is_cont  = (b[7:6] == 2'b10);
    assign acc_ext  = {acc_reg[POINT_W-7:0], b[5:0]};
    assign seen_ext = seen_reg + 2'd1;
    assign complete = (seen_ext >= needed_reg);
    assign v        = acc_ext - SUPP_BASE;

    always_comb
    begin
        is_lead   = 1'b1;
        lead_need = 2'd0;
        lead_bits = '0;
        if ((b & LEAD2_MASK) == LEAD2_PAT)
        begin
            lead_need = 2'd1;
            lead_bits = POINT_W'(b & ~LEAD2_MASK);
        end
        else if ((b & LEAD3_MASK) == LEAD3_PAT)
        begin
            lead_need = 2'd2;
            lead_bits = POINT_W'(b & ~LEAD3_MASK);
        end
        else if ((b & LEAD4_MASK) == LEAD4_PAT)
        begin
            lead_need = 2'd3;
            lead_bits = POINT_W'(b & ~LEAD4_MASK);
        end
        else
        begin
            is_lead = 1'b0;
        end
    end

    // Sequence tracking and the units caused by the byte on the input.
    always_comb
    begin
        lead_next   = lead_reg;
        acc_next    = acc_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        grp_new     = '0;
        grp_new.last = last;
        flush_en    = 1'b0;
        fresh_en    = 1'b0;
        flush_acc   = acc_reg;
        flush_seen  = seen_reg;

        if (pend && is_cont)
        begin
            if (complete)
            begin
                if (acc_ext < SUPP_BASE)
                begin
                    grp_new.units[0] = acc_ext[UNIT_W-1:0];
                    grp_new.cnt      = CNT_W'(1);
                end
                else
                begin
                    grp_new.units[0] = HI_SURR + UNIT_W'(v[POINT_W-1:10]);
                    grp_new.units[1] = LO_SURR + (v[UNIT_W-1:0] & TEN_MASK);
                    grp_new.cnt      = CNT_W'(2);
                end
                lead_next   = '0;
                acc_next    = '0;
                needed_next = 2'd0;
                seen_next   = 2'd0;
            end
            else if (last)
            begin
                flush_en   = 1'b1;
                flush_acc  = acc_ext;
                flush_seen = seen_ext;
            end
            else
            begin
                acc_next  = acc_ext;
                seen_next = seen_ext;
            end
        end
        else if (pend)
        begin
            flush_en = 1'b1;
            fresh_en = 1'b1;
        end
        else
        begin
            fresh_en = 1'b1;
        end

        // A broken or cut-off sequence goes out raw: lead byte, then held bytes.
        if (flush_en)
        begin
            grp_new.units[0] = raw_unit(lead_reg);
            case (flush_seen)
                2'd1:
                begin
                    grp_new.units[1] = raw_cont(flush_acc[5:0]);
                    grp_new.cnt      = CNT_W'(2);
                end
                2'd2:
                begin
                    grp_new.units[1] = raw_cont(flush_acc[11:6]);
                    grp_new.units[2] = raw_cont(flush_acc[5:0]);
                    grp_new.cnt      = CNT_W'(3);
                end
                default:
                begin
                    grp_new.cnt = CNT_W'(1);
                end
            endcase
            lead_next   = '0;
            acc_next    = '0;
            needed_next = 2'd0;
            seen_next   = 2'd0;
        end

        if (fresh_en)
        begin
            if (is_lead && !last)
            begin
                lead_next   = b;
                acc_next    = lead_bits;
                needed_next = lead_need;
                seen_next   = 2'd0;
            end
            else
            begin
                grp_new.units[grp_new.cnt[1:0]] = raw_unit(b);
                grp_new.cnt = grp_new.cnt + CNT_W'(1);
            end
        end
    end

    // Head group drains one unit per transfer; the skid group refills it.
    assign a_free = (a_reg.cnt == '0) || ((a_reg.cnt == CNT_W'(1)) && out_fire);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (out_fire)
        begin
            a_next.units = a_reg.units >> UNIT_W;
            a_next.cnt   = a_reg.cnt - CNT_W'(1);
        end
        if (b_reg.cnt != '0)
        begin
            if (a_free)
            begin
                a_next     = b_reg;
                b_next.cnt = '0;
            end
        end
        else if (in_fire && (grp_new.cnt != '0))
        begin
            if (a_free)
            begin
                a_next = grp_new;
            end
            else
            begin
                b_next = grp_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= '0;
            acc_reg    <= '0;
            needed_reg <= 2'd0;
            seen_reg   <= 2'd0;
        end
        else if (in_fire)
        begin
            lead_reg   <= lead_next;
            acc_reg    <= acc_next;
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    `U8U_ASSERT_IMPL(a_skid_behind_head, b_reg.cnt != '0, a_reg.cnt != '0)
    `U8U_ASSERT_IMPL(a_seen_below_needed, needed_reg != 2'd0, seen_reg < needed_reg)
    `U8U_ASSERT_NEXT(a_last_clears_seq, in_fire && last, needed_reg == 2'd0)

endmodule
